>>> rtl/core/lcc_pkg.sv
package lcc_pkg;

    localparam int unsigned DigitW  = 4;
    localparam int unsigned CountW  = 5;
    localparam int unsigned LeadW   = 7;

    localparam logic [DigitW-1:0] DigitMax  = 4'd9;
    localparam logic [CountW-1:0] CountMax  = 5'd31;
    localparam logic [CountW-1:0] AmexLen   = 5'd15;
    localparam logic [CountW-1:0] CardLen16 = 5'd16;
    localparam logic [LeadW-1:0]  AmexLeadA = 7'd34;
    localparam logic [LeadW-1:0]  AmexLeadB = 7'd37;
    localparam logic [LeadW-1:0]  McLeadLo  = 7'd51;
    localparam logic [LeadW-1:0]  McLeadHi  = 7'd55;
    localparam logic [LeadW-1:0]  VisaLeadLo = 7'd40;
    localparam logic [LeadW-1:0]  VisaLeadHi = 7'd49;
    localparam logic [4:0]        Radix     = 5'd10;

    typedef enum logic [1:0] {
        KIND_INVALID    = 2'd0,
        KIND_AMEX       = 2'd1,
        KIND_MASTERCARD = 2'd2,
        KIND_VISA       = 2'd3
    } card_kind_t;

    function automatic logic [DigitW-1:0] fold_double(input logic [DigitW-1:0] d);
        logic [DigitW:0] dbl;
        dbl = {d, 1'b0};
        if (d >= 4'd5) begin
            dbl = dbl - 5'd9;
        end
        return dbl[DigitW-1:0];
    endfunction

    function automatic logic [DigitW-1:0] add_mod10(input logic [DigitW-1:0] a,
                                                     input logic [DigitW-1:0] b);
        logic [DigitW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= Radix) begin
            s = s - Radix;
        end
        return s[DigitW-1:0];
    endfunction

    function automatic card_kind_t classify(input logic ok,
                                            input logic [CountW-1:0] len,
                                            input logic [LeadW-1:0] lead);
        card_kind_t k;
        k = KIND_INVALID;
        if (ok) begin
            if (len == AmexLen && (lead == AmexLeadA || lead == AmexLeadB)) begin
                k = KIND_AMEX;
            end else if (len == CardLen16 && lead >= McLeadLo && lead <= McLeadHi) begin
                k = KIND_MASTERCARD;
            end else if (len == CardLen16 && lead >= VisaLeadLo && lead <= VisaLeadHi) begin
                k = KIND_VISA;
            end
        end
        return k;
    endfunction

endpackage

>>> rtl/core/luhn_card_number_checker_top.sv
// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// input    | s_valid s_ready s_digit s_last_digit              | in
// result   | m_valid m_ready m_luhn_ok m_card_kind m_number_length | out
//
// One digit per cycle: input register, then sum/fold/classify logic, then result register,
// except that a last digit waits while the result is stalled. A digit reaches the running
// sums in the cycle after acceptance; a result is registered as the last digit leaves.
// Synchronous active-low reset clears valid flags, sums, count and leading pair.
// A stalled result holds only the last-digit transaction behind it; other digits flow.
module luhn_card_number_checker_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_digit,
    input  logic       s_last_digit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_luhn_ok,
    output logic [1:0] m_card_kind,
    output logic [4:0] m_number_length
);

    logic                            in_valid_reg;
    logic [lcc_pkg::DigitW-1:0]      in_digit_reg;
    logic                            in_last_reg;

    logic [lcc_pkg::DigitW-1:0]      sum_even_reg, sum_even_next;
    logic [lcc_pkg::DigitW-1:0]      sum_odd_reg, sum_odd_next;
    logic [lcc_pkg::CountW-1:0]      count_reg, count_next;
    logic [lcc_pkg::LeadW-1:0]       lead_reg, lead_next;

    logic                            out_valid_reg;
    logic                            out_ok_reg;
    lcc_pkg::card_kind_t             out_kind_reg;
    logic [lcc_pkg::CountW-1:0]      out_len_reg;

    logic                            advance;
    logic                            out_free;
    logic [lcc_pkg::DigitW-1:0]      d;
    logic [lcc_pkg::LeadW-1:0]       d_times10;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        d = (in_digit_reg > lcc_pkg::DigitMax) ? lcc_pkg::DigitMax : in_digit_reg;
        d_times10 = {d, 3'b000} + {2'b00, d, 1'b0};
        sum_even_next = lcc_pkg::add_mod10(sum_odd_reg, lcc_pkg::fold_double(d));
        sum_odd_next  = lcc_pkg::add_mod10(sum_even_reg, d);
        count_next = (count_reg == lcc_pkg::CountMax) ? lcc_pkg::CountMax
                                                      : count_reg + 5'd1;
        lead_next = lead_reg;
        if (count_reg == 5'd0) begin
            lead_next = d_times10;
        end else if (count_reg == 5'd1) begin
            lead_next = lead_reg + {3'b000, d};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_digit_reg <= s_digit;
            in_last_reg  <= s_last_digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            count_reg    <= '0;
            lead_reg     <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                sum_even_reg <= '0;
                sum_odd_reg  <= '0;
                count_reg    <= '0;
                lead_reg     <= '0;
            end else begin
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
                count_reg    <= count_next;
                lead_reg     <= lead_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && in_last_reg;
        end
        if (out_free && advance && in_last_reg) begin
            out_ok_reg   <= (sum_odd_next == '0);
            out_kind_reg <= lcc_pkg::classify(sum_odd_next == '0, count_next, lead_next);
            out_len_reg  <= count_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_luhn_ok       = out_ok_reg;
    assign m_card_kind     = out_kind_reg;
    assign m_number_length = out_len_reg;

endmodule

>>> rtl/core/lcc_checker.sv
module lcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_luhn_ok,
    input logic [1:0] m_card_kind,
    input logic [4:0] m_number_length
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luhn_ok) && $stable(m_card_kind)
                                && $stable(m_number_length))
        else $error("result changed while stalled");

    a_kind_needs_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_card_kind != lcc_pkg::KIND_INVALID |-> m_luhn_ok)
        else $error("known card kind without checksum pass");

    a_kind_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_card_kind != lcc_pkg::KIND_INVALID |->
            (m_card_kind == lcc_pkg::KIND_AMEX && m_number_length == lcc_pkg::AmexLen) ||
            (m_card_kind != lcc_pkg::KIND_AMEX && m_number_length == lcc_pkg::CardLen16))
        else $error("card kind does not match length");

    a_nonzero_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_number_length != 5'd0)
        else $error("transaction with zero digits");

endmodule

bind luhn_card_number_checker_top lcc_checker u_lcc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_luhn_ok       (m_luhn_ok),
    .m_card_kind     (m_card_kind),
    .m_number_length (m_number_length)
);

>>> tb/sv/luhn_verdict_checker.sv
module luhn_verdict_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [lcc_pkg::DigitW-1:0] s_digit,
    input  logic                      s_last_digit,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_luhn_ok,
    input  logic [1:0]                m_card_kind,
    input  logic [lcc_pkg::CountW-1:0] m_number_length,
    output int                        mismatch_count,
    output int                        verdicts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lcc_pkg::LeadW-1:0] lead_t;

    typedef struct {
        logic                       luhn_ok;
        lcc_pkg::card_kind_t        kind;
        logic [lcc_pkg::CountW-1:0] length;
    } card_verdict_t;

    card_verdict_t              verdict_q[$];
    logic [3:0]                 sum_even_dbl;
    logic [3:0]                 sum_odd_dbl;
    logic [lcc_pkg::CountW-1:0] digits_seen;
    logic [lcc_pkg::LeadW-1:0]  lead_pair;

    initial begin
        mismatch_count   = 0;
        verdicts_pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] card verdict mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic lcc_pkg::card_kind_t kind_of(input logic ok,
                                                    input logic [lcc_pkg::CountW-1:0] len,
                                                    input logic [lcc_pkg::LeadW-1:0] lead);
        if (!ok) begin
            return lcc_pkg::KIND_INVALID;
        end
        if (len == lcc_pkg::AmexLen) begin
            if (lead == lcc_pkg::AmexLeadA || lead == lcc_pkg::AmexLeadB) begin
                return lcc_pkg::KIND_AMEX;
            end
        end else if (len == lcc_pkg::CardLen16) begin
            if (lead >= lcc_pkg::McLeadLo && lead <= lcc_pkg::McLeadHi) begin
                return lcc_pkg::KIND_MASTERCARD;
            end
            if (lead >= lcc_pkg::VisaLeadLo && lead <= lcc_pkg::VisaLeadHi) begin
                return lcc_pkg::KIND_VISA;
            end
        end
        return lcc_pkg::KIND_INVALID;
    endfunction

    task automatic clear_card_state();
        sum_even_dbl = '0;
        sum_odd_dbl  = '0;
        digits_seen  = '0;
        lead_pair    = '0;
    endtask

    task automatic absorb_digit(input logic [lcc_pkg::DigitW-1:0] raw, input logic is_last);
        int                         dv;
        int                         dbl;
        logic [3:0]                 next_even;
        logic [3:0]                 next_odd;
        logic [lcc_pkg::CountW-1:0] next_count;
        logic [lcc_pkg::LeadW-1:0]  next_lead;
        card_verdict_t              v;
        dv  = (raw > lcc_pkg::DigitMax) ? int'(lcc_pkg::DigitMax) : int'(raw);
        dbl = 2 * dv;
        if (dbl > 9) begin
            dbl = dbl - 9;
        end
        next_even = 4'((int'(sum_odd_dbl) + dbl) % 10);
        next_odd  = 4'((int'(sum_even_dbl) + dv) % 10);
        next_lead = lead_pair;
        if (digits_seen == 0) begin
            next_lead = lead_t'(dv * 10);
        end else if (digits_seen == 1) begin
            next_lead = lead_t'(int'(lead_pair) + dv);
        end
        next_count = (digits_seen == lcc_pkg::CountMax) ? lcc_pkg::CountMax
                                                        : digits_seen + 1'b1;
        if (is_last) begin
            v.luhn_ok = (next_odd == 4'd0);
            v.kind    = kind_of(v.luhn_ok, next_count, next_lead);
            v.length  = next_count;
            verdict_q.push_back(v);
            clear_card_state();
        end else begin
            sum_even_dbl = next_even;
            sum_odd_dbl  = next_odd;
            digits_seen  = next_count;
            lead_pair    = next_lead;
        end
    endtask

    always @(posedge aclk) begin
        card_verdict_t got;
        if (!aresetn) begin
            clear_card_state();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result, length", m_number_length, 0);
                end else begin
                    got = verdict_q.pop_front();
                    if (m_luhn_ok !== got.luhn_ok) begin
                        report_mismatch("luhn_ok", m_luhn_ok, got.luhn_ok);
                    end
                    if (m_card_kind !== got.kind) begin
                        report_mismatch("card_kind", m_card_kind, got.kind);
                    end
                    if (m_number_length !== got.length) begin
                        report_mismatch("number_length", m_number_length, got.length);
                    end
                end
            end
            if (s_valid && s_ready) begin
                absorb_digit(s_digit, s_last_digit);
            end
        end
        verdicts_pending = verdict_q.size();
    end

endmodule

>>> tb/sv/luhn_card_number_checker_top_test.sv
module luhn_card_number_checker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit     = 200000;
    localparam int DigitsPerPhase = 460;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [3:0] s_digit      = 4'd0;
    logic       s_last_digit = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic       m_luhn_ok;
    logic [1:0] m_card_kind;
    logic [4:0] m_number_length;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int digits_sent   = 0;
    int cycle_count   = 0;
    int mismatch_count;
    int verdicts_pending;

    luhn_card_number_checker_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_digit         (s_digit),
        .s_last_digit    (s_last_digit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_luhn_ok       (m_luhn_ok),
        .m_card_kind     (m_card_kind),
        .m_number_length (m_number_length)
    );

    luhn_verdict_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_digit          (s_digit),
        .s_last_digit     (s_last_digit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_luhn_ok        (m_luhn_ok),
        .m_card_kind      (m_card_kind),
        .m_number_length  (m_number_length),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("luhn_card_number_checker_top_test NOT OK");
            $finish;
        end
    end

    task automatic send_digit(input logic [3:0] d, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_digit      <= d;
        s_last_digit <= is_last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        digits_sent++;
    endtask

    task automatic send_number(input logic [3:0] digits[$]);
        for (int i = 0; i < digits.size(); i++) begin
            send_digit(digits[i], i == digits.size() - 1);
        end
    endtask

    function automatic logic [3:0] check_digit_for(input logic [3:0] head[$]);
        int total;
        int v;
        int n;
        total = 0;
        n     = head.size();
        for (int i = 0; i < n; i++) begin
            v = (head[i] > 4'd9) ? 9 : int'(head[i]);
            if (((n - i) % 2) == 1) begin
                v = (v >= 5) ? 2 * v - 9 : 2 * v;
            end
            total += v;
        end
        return 4'((10 - total % 10) % 10);
    endfunction

    function automatic logic [3:0] body_digit();
        return ($urandom_range(15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
    endfunction

    task automatic send_random_card();
        logic [3:0] digits[$];
        int         len;
        int         first;
        int         second;
        if ($urandom_range(99) < 85) begin
            case ($urandom_range(3))
                0: begin
                    len    = 15;
                    first  = 3;
                    second = $urandom_range(1) ? 4 : 7;
                end
                1: begin
                    len    = 16;
                    first  = 5;
                    second = $urandom_range(1, 5);
                end
                2: begin
                    len    = 16;
                    first  = 4;
                    second = $urandom_range(9);
                end
                default: begin
                    len    = $urandom_range(1) ? 15 : 16;
                    first  = $urandom_range(9);
                    second = $urandom_range(9);
                end
            endcase
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(13, 18);
            end
            digits.push_back(4'(first));
            digits.push_back(4'(second));
            while (digits.size() < len - 1) begin
                digits.push_back(body_digit());
            end
            if ($urandom_range(9) < 7) begin
                digits.push_back(check_digit_for(digits));
            end else begin
                digits.push_back(4'($urandom_range(15)));
            end
        end else begin
            len = ($urandom_range(3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
            repeat (len) begin
                digits.push_back(4'($urandom_range(15)));
            end
        end
        send_number(digits);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_number('{4'd0});
        send_number('{4'd15});
        send_number('{4'd9, 4'd12});
        send_number('{4'd3, 4'd7, 4'd8, 4'd2, 4'd8, 4'd2, 4'd2, 4'd4,
                      4'd6, 4'd3, 4'd1, 4'd0, 4'd0, 4'd0, 4'd5});

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 55;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 55;
                end
                default: begin
                    send_idle_pct = 14;
                    stall_pct     = 14;
                end
            endcase
            while (digits_sent < (phase + 1) * DigitsPerPhase) begin
                send_random_card();
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (verdicts_pending != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("luhn_card_number_checker_top_test OK");
        end else begin
            $display("luhn_card_number_checker_top_test NOT OK");
        end
        $finish;
    end

endmodule
